// File: hdl/http_chunked_body_decoder_macros.svh
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HCBD_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("hcbd same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define HCBD_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("hcbd next-cycle check failed");

`endif

// File: hdl/hcbd_pkg.sv
`default_nettype none
package hcbd_pkg;

	localparam int SIZE_BITS   = 32;
	localparam int LENGTH_BITS = 24;
	localparam int Q_DEPTH     = 4;
	localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] SKIP_LEN = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]             out_byte;
		logic                   out_is_data;
		logic                   out_end;
		logic [LENGTH_BITS-1:0] body_length;
	} out_beat_t;

	// per-byte classification done in the front end
	typedef struct packed {
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_space;
		logic       is_sign;
		logic       is_minus;
		logic       is_x;
		logic       is_cr;
		logic       is_lf;
	} byte_class_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		byte_class_t cls;
	} q_entry_t;

endpackage
`default_nettype wire

// File: hdl/hcbd_if.sv
`default_nettype none
interface hcbd_in_if;
	logic               valid;
	logic               ready;
	hcbd_pkg::in_beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hcbd_out_if;
	logic                valid;
	logic                ready;
	hcbd_pkg::out_beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/http_chunked_body_decoder.sv
// channel   dir  beat payload                                   handshake
// body      in   in_byte[7:0], in_last                          valid/ready
// payload   out  out_byte[7:0], out_is_data, out_end,           valid/ready
//                body_length[23:0]
//
// one byte per clock sustained while payload is ready; each byte is stored in
// the queue, then sees one pass through the back-end state update into out_q
// a four-entry queue sits between the classifier and the state machine
// a payload beat is produced for each data byte and for the last byte
// arst_n clears the queue, the decoder state and the output valid flag
// a stalled payload side fills the queue, then body.ready drops
`default_nettype none
module http_chunked_body_decoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hcbd_in_if.sink     body,
	hcbd_out_if.source  payload
);
	import hcbd_pkg::*;

	logic     q_full;
	logic     q_push;
	logic     q_pop;
	logic     q_valid;
	q_entry_t q_wdata;
	q_entry_t q_rdata;

	hcbd_front u_front (
		.body    (body),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	hcbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (q_rdata)
	);

	hcbd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.payload (payload)
	);

endmodule
`default_nettype wire

// File: hdl/hcbd_front.sv
`default_nettype none
module hcbd_front (
	hcbd_in_if.sink           body,
	input  wire logic         q_full,
	output logic              q_push,
	output hcbd_pkg::q_entry_t q_wdata
);
	import hcbd_pkg::*;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	function automatic byte_class_t classify(input logic [7:0] b);
		byte_class_t c;
		c = '0;
		case (b) inside
			[8'h30:8'h39]: begin
				c.is_hex  = 1'b1;
				c.hex_val = b[3:0];
			end
			[8'h41:8'h46], [8'h61:8'h66]: begin
				c.is_hex  = 1'b1;
				c.hex_val = b[3:0] + 4'd9;
			end
			default: c.is_hex = 1'b0;
		endcase
		c.is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
			(b == CH_VT) || (b == CH_FF) || (b == CH_CR);
		c.is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
		c.is_minus = (b == CH_MINUS);
		c.is_x     = (b == CH_X_UP) || (b == CH_X_LO);
		c.is_cr    = (b == CH_CR);
		c.is_lf    = (b == CH_LF);
		return c;
	endfunction

	assign body.ready   = !q_full;
	assign q_push       = body.valid && !q_full;
	assign q_wdata.data = body.data.in_byte;
	assign q_wdata.last = body.data.in_last;
	assign q_wdata.cls  = classify(body.data.in_byte);

endmodule
`default_nettype wire

// File: hdl/hcbd_queue.sv
`default_nettype none
module hcbd_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire hcbd_pkg::q_entry_t wdata,
	output logic                    full,
	input  wire logic               pop,
	output logic                    rvalid,
	output hcbd_pkg::q_entry_t      rdata
);
	import hcbd_pkg::*;

	q_entry_t                 mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0]    wr_ptr_q;
	logic [Q_PTR_BITS-1:0]    rd_ptr_q;
	logic [Q_CNT_BITS-1:0]    count_q;

	assign full   = (count_q == Q_CNT_BITS'(Q_DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/hcbd_back.sv
`default_nettype none
`include "http_chunked_body_decoder_macros.svh"
module hcbd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire hcbd_pkg::q_entry_t q_rdata,
	output logic                    q_pop,
	hcbd_out_if.source              payload
);
	import hcbd_pkg::*;

	typedef enum logic [7:0] {
		PH_WS   = 8'b0000_0001,
		PH_SIGN = 8'b0000_0010,
		PH_NUM  = 8'b0000_0100,
		PH_XPFX = 8'b0000_1000,
		PH_EXT  = 8'b0001_0000,
		PH_DATA = 8'b0010_0000,
		PH_SKIP = 8'b0100_0000,
		PH_STOP = 8'b1000_0000
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [SIZE_BITS-1:0]   chunk_q, chunk_n, chunk_dec, digit_val;
	logic [SIZE_BITS+3:0]   digit_sum;
	logic                   neg_q, neg_n;
	logic                   dig_q, dig_n;
	logic                   pz_q, pz_n;
	logic                   cr_q, cr_n;
	logic [1:0]             skip_q, skip_n, skip_dec;
	logic [LENGTH_BITS-1:0] len_q, len_n;
	logic                   emit, num_byte, has_result;
	logic                   out_valid_q;
	out_beat_t              out_q;
	byte_class_t            c;

	assign c          = q_rdata.cls;
	assign q_pop      = q_valid && (!out_valid_q || payload.ready);
	assign has_result = emit || q_rdata.last;

	// saturating shift-in of one hex digit
	assign digit_sum = {chunk_q, 4'h0} + {{SIZE_BITS{1'b0}}, c.hex_val};
	assign digit_val = (|digit_sum[SIZE_BITS+3:SIZE_BITS]) ? '1 : digit_sum[SIZE_BITS-1:0];
	assign chunk_dec = (chunk_q != '0) ? chunk_q - 1'b1 : chunk_q;
	assign skip_dec  = (skip_q != '0) ? skip_q - 1'b1 : skip_q;

	always_comb begin
		phase_n  = phase_q;
		chunk_n  = chunk_q;
		neg_n    = neg_q;
		dig_n    = dig_q;
		pz_n     = pz_q;
		skip_n   = skip_q;
		emit     = 1'b0;
		num_byte = 1'b0;
		case (phase_q)
			PH_WS: begin
				if (c.is_lf && cr_q) begin
					phase_n = PH_STOP;
				end else if (c.is_space) begin
					phase_n = PH_WS;
				end else if (c.is_sign) begin
					neg_n   = c.is_minus;
					phase_n = PH_SIGN;
				end else begin
					num_byte = 1'b1;
				end
			end
			PH_SIGN, PH_XPFX: begin
				num_byte = 1'b1;
			end
			PH_NUM: begin
				if (c.is_x && pz_q) begin
					pz_n    = 1'b0;
					phase_n = PH_XPFX;
				end else begin
					num_byte = 1'b1;
				end
			end
			PH_EXT: begin
				if (c.is_lf && cr_q) begin
					phase_n = (dig_q && !neg_q && chunk_q != '0) ? PH_DATA : PH_STOP;
				end
			end
			PH_DATA: begin
				emit    = 1'b1;
				chunk_n = chunk_dec;
				if (chunk_dec == '0) begin
					skip_n  = SKIP_LEN;
					phase_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_n = skip_dec;
				if (skip_dec == '0) begin
					phase_n = PH_WS;
					chunk_n = '0;
					neg_n   = 1'b0;
					dig_n   = 1'b0;
					pz_n    = 1'b0;
				end
			end
			default: phase_n = PH_STOP;
		endcase
		if (num_byte) begin
			if (c.is_hex) begin
				pz_n    = !dig_q && (c.hex_val == 4'h0);
				chunk_n = digit_val;
				dig_n   = 1'b1;
				phase_n = PH_NUM;
			end else begin
				pz_n    = 1'b0;
				phase_n = PH_EXT;
			end
		end
		cr_n  = c.is_cr && (phase_n inside {PH_WS, PH_SIGN, PH_NUM, PH_XPFX, PH_EXT});
		len_n = (emit && len_q != '1) ? len_q + 1'b1 : len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WS;
			chunk_q     <= '0;
			neg_q       <= 1'b0;
			dig_q       <= 1'b0;
			pz_q        <= 1'b0;
			cr_q        <= 1'b0;
			skip_q      <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_rdata.last) begin
					// end of body: back to a fresh decoder
					phase_q <= PH_WS;
					chunk_q <= '0;
					neg_q   <= 1'b0;
					dig_q   <= 1'b0;
					pz_q    <= 1'b0;
					cr_q    <= 1'b0;
					skip_q  <= '0;
					len_q   <= '0;
				end else begin
					phase_q <= phase_n;
					chunk_q <= chunk_n;
					neg_q   <= neg_n;
					dig_q   <= dig_n;
					pz_q    <= pz_n;
					cr_q    <= cr_n;
					skip_q  <= skip_n;
					len_q   <= len_n;
				end
			end
			if (q_pop && has_result) begin
				out_valid_q <= 1'b1;
			end else if (payload.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_result) begin
			out_q.out_byte    <= emit ? q_rdata.data : 8'h00;
			out_q.out_is_data <= emit;
			out_q.out_end     <= q_rdata.last;
			out_q.body_length <= len_n;
		end
	end

	assign payload.valid = out_valid_q;
	assign payload.data  = out_q;

	`HCBD_ASSERT_IMP(a_pop_needs_entry, q_pop, q_valid)
	`HCBD_ASSERT_IMP(a_no_pop_on_stall, out_valid_q && !payload.ready, !q_pop)
	`HCBD_ASSERT_IMP(a_data_has_bytes, phase_q == PH_DATA, chunk_q != '0)
	`HCBD_ASSERT_IMP(a_skip_has_count, phase_q == PH_SKIP, skip_q != '0)
	`HCBD_ASSERT_NXT(a_end_clears_len, q_pop && q_rdata.last, len_q == '0)

endmodule
`default_nettype wire
